[design/sqm_pkg.sv]
// Shared types and constants for the shadow queue AQM marker.
// Used by every module of the block; depends on nothing.
package sqm_pkg;

    // Fixed-point and reset constants
    localparam int FRAC_BITS = 16;
    localparam logic [16:0] FRAC_ONE = 17'(1 << FRAC_BITS);
    localparam logic [15:0] RESET_LIMIT = 16'd1000;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_LIMIT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PROB    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EWMA_WEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ECN_ENABLE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY    = 3'd4;

    // Verdict codes
    localparam logic [1:0] VERDICT_PASS      = 2'd0;
    localparam logic [1:0] VERDICT_CE        = 2'd1;
    localparam logic [1:0] VERDICT_DROP_FULL = 2'd2;
    localparam logic [1:0] VERDICT_DROP_PROB = 2'd3;

    // Queue depths
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);
    localparam int RESQ_DEPTH = 2;
    localparam int RESQ_PTR_W = $clog2(RESQ_DEPTH);
    localparam int RESQ_CNT_W = $clog2(RESQ_DEPTH + 1);

    // Probability division: 65-bit dividend, one quotient bit per cycle
    localparam int DIV_STEPS = 65;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Classified command kinds
    typedef enum logic [1:0] {
        KIND_PKT,
        KIND_FULL,
        KIND_TICK
    } cmd_kind_t;

    // Command from front to back
    typedef struct packed {
        cmd_kind_t   kind;
        logic [15:0] packet_length;
        logic [31:0] backlog_bytes;
        logic        ecn_capable;
        logic [31:0] random_value;
    } cmd_t;

    // Configuration seen by the back end
    typedef struct packed {
        logic [16:0] max_probability;
        logic [16:0] ewma_weight;
        logic        ecn_enable;
        logic [31:0] interval_byte_capacity;
    } cfg_t;

    // Result transaction
    typedef struct packed {
        logic [1:0]  verdict;
        logic [32:0] mark_probability;
        logic [47:0] average_queue;
    } res_t;

    // Clamp a 1.16 fraction to one
    function automatic logic [16:0] clamp_frac(input logic [16:0] v);
        clamp_frac = (v > FRAC_ONE) ? FRAC_ONE : v;
    endfunction

endpackage

[design/shadow_queue_aqm_marker.sv]
// Top level of the shadow queue AQM marker: config registers and wiring.
// Depends on sqm_pkg, sqm_front, sqm_back and sqm_result_q.
//
//   Channel  Handshake          Payload
//   input    push / full        op, packet_length, queue_packets, backlog_bytes,
//                               ecn_capable, random_value
//   result   empty / pop        verdict, mark_probability, average_queue
//   config   cfg_write          cfg_index, cfg_data
//
// A packet arrival (queue-full drop or normal) is handled in the back end's idle state,
// so packets sustain one transaction per clock while no tick runs and the result queue has room.
// An interval tick, when the capacity is nonzero, runs take, five multiply steps on
// one 32x17 multiplier, 65 divide steps at one quotient bit per cycle, clamp and
// output; when the capacity is zero it skips the divide and clamp.
// Reset clears state, config goes to its reset values; no clearing pass.
// Either side may stall: two-entry queues sit on the input and result sides.
module shadow_queue_aqm_marker
    import sqm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic                 op,
    input  logic [15:0]          packet_length,
    input  logic [15:0]          queue_packets,
    input  logic [31:0]          backlog_bytes,
    input  logic                 ecn_capable,
    input  logic [31:0]          random_value,
    output logic                 empty,
    input  logic                 pop,
    output logic [1:0]           verdict,
    output logic [32:0]          mark_probability,
    output logic [47:0]          average_queue,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    logic [15:0] queue_limit_reg;
    cfg_t        cfg_reg;
    logic        cmd_valid;
    cmd_t        cmd;
    logic        cmd_take;
    logic        res_ready;
    logic        res_push;
    res_t        res_in;
    res_t        res_out;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            queue_limit_reg                <= RESET_LIMIT;
            cfg_reg.max_probability        <= FRAC_ONE;
            cfg_reg.ewma_weight            <= '0;
            cfg_reg.ecn_enable             <= 1'b1;
            cfg_reg.interval_byte_capacity <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_QUEUE_LIMIT: queue_limit_reg                <= cfg_data[15:0];
                CFG_MAX_PROB:    cfg_reg.max_probability        <= cfg_data[16:0];
                CFG_EWMA_WEIGHT: cfg_reg.ewma_weight            <= cfg_data[16:0];
                CFG_ECN_ENABLE:  cfg_reg.ecn_enable             <= cfg_data[0];
                CFG_CAPACITY:    cfg_reg.interval_byte_capacity <= cfg_data;
                default:         ;
            endcase
        end
    end

    sqm_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .op            (op),
        .packet_length (packet_length),
        .queue_packets (queue_packets),
        .backlog_bytes (backlog_bytes),
        .ecn_capable   (ecn_capable),
        .random_value  (random_value),
        .queue_limit   (queue_limit_reg),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_take      (cmd_take)
    );

    sqm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .res_ready (res_ready),
        .res_push  (res_push),
        .res       (res_in)
    );

    sqm_result_q u_result_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_push  (res_push),
        .res_in    (res_in),
        .res_ready (res_ready),
        .empty     (empty),
        .pop       (pop),
        .res_out   (res_out)
    );

    assign verdict          = res_out.verdict;
    assign mark_probability = res_out.mark_probability;
    assign average_queue    = res_out.average_queue;

endmodule

[design/sqm_front.sv]
// Front end: classifies arriving items and holds them in a short command queue.
// Depends on sqm_pkg.
module sqm_front
    import sqm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        op,
    input  logic [15:0] packet_length,
    input  logic [15:0] queue_packets,
    input  logic [31:0] backlog_bytes,
    input  logic        ecn_capable,
    input  logic [31:0] random_value,
    input  logic [15:0] queue_limit,
    output logic        cmd_valid,
    output cmd_t        cmd,
    input  logic        cmd_take
);

    cmd_t                  entry_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wr_ptr_reg;
    logic [CMDQ_PTR_W-1:0] rd_ptr_reg;
    logic [CMDQ_CNT_W-1:0] count_reg;
    cmd_t                  cls;
    logic                  do_push;
    logic                  do_pop;

    // Classify the incoming item
    always_comb
    begin
        cls.packet_length = packet_length;
        cls.backlog_bytes = backlog_bytes;
        cls.ecn_capable   = ecn_capable;
        cls.random_value  = random_value;
        if (op)
        begin
            cls.kind = KIND_TICK;
        end
        else if (queue_packets >= queue_limit)
        begin
            cls.kind = KIND_FULL;
        end
        else
        begin
            cls.kind = KIND_PKT;
        end
    end

    assign full      = (count_reg == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_take && cmd_valid;

    // Queue pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

[design/sqm_back.sv]
// Back end: applies packet verdicts and runs the interval update
// (EWMA, probability multiply and bit-serial divide). Depends on sqm_pkg.
module sqm_back
    import sqm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic cmd_valid,
    input  cmd_t cmd,
    output logic cmd_take,
    input  logic res_ready,
    output logic res_push,
    output res_t res
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_AVG_LO,
        S_AVG_HI,
        S_AVG_SUM,
        S_P_LO,
        S_P_HI,
        S_DIV,
        S_CLAMP,
        S_DONE
    } state_t;

    state_t               state_reg, state_next;
    logic [31:0]          ib_reg, ib_next;
    logic [47:0]          avg_reg, avg_next;
    logic [32:0]          prob_reg, prob_next;
    logic [31:0]          sum_reg, sum_next;
    logic [64:0]          acc_reg, acc_next;
    logic [31:0]          rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;

    logic [16:0] alpha;
    logic [16:0] beta;
    logic [16:0] maxp;
    logic [32:0] limit_p;
    logic [31:0] mul_a;
    logic [16:0] mul_b;
    logic [48:0] mul_p;
    logic [32:0] pkt_sum;
    logic [32:0] tick_sum;
    logic [32:0] rem_sh;
    logic [33:0] diff;
    logic        ge;

    // Clamped configuration
    assign alpha   = clamp_frac(cfg.ewma_weight);
    assign beta    = FRAC_ONE - alpha;
    assign maxp    = clamp_frac(cfg.max_probability);
    assign limit_p = {maxp, 16'b0};

    // Shared multiplier operand select
    always_comb
    begin
        case (state_reg)
            S_AVG_LO:
            begin
                mul_a = {8'b0, avg_reg[23:0]};
                mul_b = beta;
            end
            S_AVG_HI:
            begin
                mul_a = {8'b0, avg_reg[47:24]};
                mul_b = beta;
            end
            S_AVG_SUM:
            begin
                mul_a = sum_reg;
                mul_b = alpha;
            end
            S_P_LO:
            begin
                mul_a = {8'b0, avg_reg[23:0]};
                mul_b = maxp;
            end
            S_P_HI:
            begin
                mul_a = {8'b0, avg_reg[47:24]};
                mul_b = maxp;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = 49'(mul_a) * 49'(mul_b);

    // Saturating adds for byte count
    assign pkt_sum  = {1'b0, ib_reg} + {17'b0, cmd.packet_length};
    assign tick_sum = {1'b0, ib_reg} + {1'b0, cmd.backlog_bytes};

    // Restoring divide step
    assign rem_sh = {rem_reg, acc_reg[64]};
    assign diff   = {1'b0, rem_sh} - {2'b0, cfg.interval_byte_capacity};
    assign ge     = !diff[33];

    // Next-state logic
    always_comb
    begin
        state_next = state_reg;
        ib_next    = ib_reg;
        avg_next   = avg_reg;
        prob_next  = prob_reg;
        sum_next   = sum_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        cmd_take   = 1'b0;
        res_push   = 1'b0;
        res.verdict          = VERDICT_PASS;
        res.mark_probability = prob_reg;
        res.average_queue    = avg_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.kind)
                        KIND_TICK:
                        begin
                            cmd_take   = 1'b1;
                            sum_next   = tick_sum[32] ? '1 : tick_sum[31:0];
                            state_next = S_AVG_LO;
                        end
                        KIND_FULL:
                        begin
                            if (res_ready)
                            begin
                                cmd_take    = 1'b1;
                                res_push    = 1'b1;
                                res.verdict = VERDICT_DROP_FULL;
                            end
                        end
                        default:
                        begin
                            if (res_ready)
                            begin
                                cmd_take = 1'b1;
                                res_push = 1'b1;
                                ib_next  = pkt_sum[32] ? '1 : pkt_sum[31:0];
                                if ({1'b0, cmd.random_value} < prob_reg)
                                begin
                                    res.verdict = (cfg.ecn_enable && cmd.ecn_capable) ?
                                                  VERDICT_CE : VERDICT_DROP_PROB;
                                end
                            end
                        end
                    endcase
                end
            end
            S_AVG_LO:
            begin
                acc_next   = 65'(mul_p);
                state_next = S_AVG_HI;
            end
            S_AVG_HI:
            begin
                acc_next   = acc_reg + (65'(mul_p) << 24);
                state_next = S_AVG_SUM;
            end
            S_AVG_SUM:
            begin
                // (avg*beta + (s<<16)*alpha) >> 16 = (avg*beta >> 16) + s*alpha
                avg_next   = 48'(acc_reg[64:16]) + 48'(mul_p);
                state_next = S_P_LO;
            end
            S_P_LO:
            begin
                acc_next   = 65'(mul_p);
                state_next = S_P_HI;
            end
            S_P_HI:
            begin
                acc_next = acc_reg + (65'(mul_p) << 24);
                if (cfg.interval_byte_capacity == '0)
                begin
                    prob_next  = limit_p;
                    ib_next    = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                rem_next = ge ? diff[31:0] : rem_sh[31:0];
                acc_next = {acc_reg[63:0], ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_CLAMP;
                end
            end
            S_CLAMP:
            begin
                prob_next  = (acc_reg > {32'b0, limit_p}) ? limit_p : acc_reg[32:0];
                ib_next    = '0;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    res_push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ib_reg    <= '0;
            avg_reg   <= '0;
            prob_reg  <= '0;
            sum_reg   <= '0;
            acc_reg   <= '0;
            rem_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ib_reg    <= ib_next;
            avg_reg   <= avg_next;
            prob_reg  <= prob_next;
            sum_reg   <= sum_next;
            acc_reg   <= acc_next;
            rem_reg   <= rem_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

[design/sqm_result_q.sv]
// Result queue: two-entry buffer between back end and the result ports.
// Depends on sqm_pkg.
module sqm_result_q
    import sqm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic res_push,
    input  res_t res_in,
    output logic res_ready,
    output logic empty,
    input  logic pop,
    output res_t res_out
);

    res_t                  entry_reg [RESQ_DEPTH];
    logic [RESQ_PTR_W-1:0] wr_ptr_reg;
    logic [RESQ_PTR_W-1:0] rd_ptr_reg;
    logic [RESQ_CNT_W-1:0] count_reg;
    logic                  do_push;
    logic                  do_pop;

    assign res_ready = (count_reg != RESQ_CNT_W'(RESQ_DEPTH));
    assign empty     = (count_reg == '0);
    assign res_out   = entry_reg[rd_ptr_reg];
    assign do_push   = res_push && res_ready;
    assign do_pop    = pop && !empty;

    // Pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == RESQ_PTR_W'(RESQ_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == RESQ_PTR_W'(RESQ_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= res_in;
        end
    end

endmodule
